[src/daf_pkg.sv]
`default_nettype none

package daf_pkg;

    // Command codes carried in the cmd field of an input word.
    typedef enum logic [1:0] {
        CMD_PLAIN  = 2'd0,
        CMD_PADDED = 2'd1,
        CMD_TIME   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Number source selected for the next conversion.
    typedef enum logic [1:0] {
        FLD_VALUE   = 2'd0,
        FLD_HOURS   = 2'd1,
        FLD_MINUTES = 2'd2,
        FLD_SECONDS = 2'd3
    } t_field;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LOAD  = 3'd1,
        ST_DIV   = 3'd2,
        ST_PAD   = 3'd3,
        ST_EMIT  = 3'd4,
        ST_COLON = 3'd5
    } t_state;

    localparam int unsigned DIGITS_MAX  = 5;
    localparam int unsigned DIGIT_IDX_W = $clog2(DIGITS_MAX);
    localparam int unsigned COUNT_W     = $clog2(DIGITS_MAX + 1);
    localparam int unsigned FIELD_CNT_W = 2;

    localparam logic [5:0]  ASCII_ZERO  = 6'd48;
    localparam logic [5:0]  ASCII_COLON = 6'd58;
    localparam logic [15:0] TEN         = 16'd10;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x.
    localparam logic [31:0] DIV10_MULT  = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] value;
        logic [7:0]  hours;
        logic [7:0]  minutes;
        logic [7:0]  seconds;
    } t_in_word;

    typedef struct packed {
        logic [5:0] char_code;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic   capture;
        logic   load;
        t_field field;
        logic   div_step;
        logic   pop;
        logic   put_zero;
        logic   put_colon;
        logic   last;
    } t_dp_ctrl;

    typedef struct packed {
        logic quot_zero;
        logic count_zero;
        logic count_one;
    } t_dp_stat;

endpackage

`default_nettype wire

[src/daf_datapath.sv]
`default_nettype none

module daf_datapath
    import daf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_in,
    input  wire t_dp_ctrl  i_ctrl,
    output t_dp_stat       o_stat,
    output logic           o_strobe,
    output t_out_word      o_out
);

    t_in_word             r_in;
    logic [15:0]          r_work;
    logic [3:0]           r_digits [DIGITS_MAX];
    logic [COUNT_W-1:0]   r_count;
    logic                 r_strobe;
    t_out_word            r_out;

    logic [31:0]          w_prod;
    logic [15:0]          w_quot;
    logic [15:0]          w_quot_x10;
    logic [15:0]          w_rem_full;
    logic [3:0]           w_rem;
    logic [15:0]          w_load_val;
    logic [COUNT_W-1:0]   w_top;
    logic [3:0]           w_top_digit;
    t_out_word            n_out;
    logic                 n_strobe;

    // One decimal digit per step: quotient by reciprocal multiply, then remainder.
    // The quotient of a 16-bit value by ten fits in the 13 bits above the shift.
    assign w_prod     = {16'd0, r_work} * DIV10_MULT;
    assign w_quot     = {3'b000, w_prod[DIV10_SHIFT +: 13]};
    assign w_quot_x10 = (w_quot << 3) + (w_quot << 1);
    assign w_rem_full = r_work - w_quot_x10;
    assign w_rem      = w_rem_full[3:0];

    always_comb begin
        case (i_ctrl.field)
            FLD_VALUE:   w_load_val = r_in.value;
            FLD_HOURS:   w_load_val = {8'd0, r_in.hours};
            FLD_MINUTES: w_load_val = {8'd0, r_in.minutes};
            FLD_SECONDS: w_load_val = {8'd0, r_in.seconds};
            default:     w_load_val = r_in.value;
        endcase
    end

    assign w_top       = r_count - COUNT_W'(1);
    assign w_top_digit = r_digits[w_top[DIGIT_IDX_W-1:0]];

    always_comb begin
        n_strobe        = 1'b0;
        n_out.char_code = ASCII_ZERO;
        n_out.last      = 1'b0;
        if (i_ctrl.pop) begin
            n_strobe        = 1'b1;
            n_out.char_code = ASCII_ZERO + {2'b00, w_top_digit};
            n_out.last      = i_ctrl.last;
        end else if (i_ctrl.put_zero) begin
            n_strobe        = 1'b1;
        end else if (i_ctrl.put_colon) begin
            n_strobe        = 1'b1;
            n_out.char_code = ASCII_COLON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_in <= i_in;
        end
        if (i_ctrl.load) begin
            r_work <= w_load_val;
        end else if (i_ctrl.div_step) begin
            r_work <= w_quot;
        end
        if (i_ctrl.div_step) begin
            r_digits[r_count[DIGIT_IDX_W-1:0]] <= w_rem;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_ctrl.load) begin
                r_count <= '0;
            end else if (i_ctrl.div_step) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (i_ctrl.pop) begin
                r_count <= w_top;
            end
        end
    end

    assign o_stat.quot_zero  = (w_quot == 16'd0);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == COUNT_W'(1));
    assign o_strobe          = r_strobe;
    assign o_out             = r_out;

endmodule

`default_nettype wire

[src/daf_controller.sv]
`default_nettype none

module daf_controller
    import daf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_cmd,
    input  wire t_dp_stat   i_stat,
    output t_dp_ctrl        o_ctrl,
    output logic            o_busy
);

    t_state                 r_state;
    t_state                 n_state;
    t_cmd                   r_mode;
    t_cmd                   n_mode;
    logic [FIELD_CNT_W-1:0] r_field;
    logic [FIELD_CNT_W-1:0] n_field;
    logic                   w_final_field;

    assign w_final_field = (r_mode != CMD_TIME) || (r_field == FIELD_CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= CMD_PLAIN;
            r_field <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_field <= n_field;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_field = r_field;
        o_ctrl  = '0;
        o_ctrl.field = FLD_VALUE;
        if (r_mode == CMD_TIME) begin
            case (r_field)
                FIELD_CNT_W'(0): o_ctrl.field = FLD_HOURS;
                FIELD_CNT_W'(1): o_ctrl.field = FLD_MINUTES;
                default:         o_ctrl.field = FLD_SECONDS;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.capture = 1'b1;
                    n_mode  = t_cmd'(i_cmd);
                    n_field = '0;
                    // The unused command produces no words at all.
                    if (t_cmd'(i_cmd) != CMD_NONE) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_ctrl.load = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_stat.quot_zero) begin
                    // A single digit in a padded mode gets a leading zero.
                    if (i_stat.count_zero && (r_mode != CMD_PLAIN)) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_PAD: begin
                o_ctrl.put_zero = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_ctrl.pop  = 1'b1;
                o_ctrl.last = i_stat.count_one && w_final_field;
                if (i_stat.count_one) begin
                    n_state = w_final_field ? ST_IDLE : ST_COLON;
                end
            end
            ST_COLON: begin
                o_ctrl.put_colon = 1'b1;
                n_field = r_field + FIELD_CNT_W'(1);
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

[src/decimal_ascii_formatter.sv]
`default_nettype none

// Channel   Handshake             Payload           Accepted when
// input     start / busy          i_in (t_in_word)  start high and busy low
// result    o_strobe              o_out (t_out_word) every cycle o_strobe is high
//
// A word is captured, then each number is loaded, split into decimal digits one
// per step in the divide-by-ten unit and emitted one character at a time, plus
// a leading zero and a colon where needed. The unused command emits nothing.
// Results leave at most one per cycle through an output register; the receiver
// cannot stall. Reset is synchronous and active low and returns the block to idle.

module decimal_ascii_formatter
    import daf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_word i_in,
    output logic          o_strobe,
    output t_out_word     o_out
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    daf_controller u_controller (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_in.cmd),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    daf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
